/* rtl/sqs_pkg.sv */
package sqs_pkg;

	localparam int CAPACITY_DEF = 256;
	localparam logic [15:0] EPS_RESET = 16'd655;
	localparam logic [9:0] LIMIT_RESET = 10'd50;
	localparam logic [15:0] EPS_MIN = 16'd66;
	localparam logic [15:0] EPS_MAX = 16'd32768;
	localparam logic [16:0] PCT_MAX = 17'd65536;

	localparam logic REQ_ADD = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic CFG_EPS = 1'b0;
	localparam logic CFG_LIMIT = 1'b1;

	typedef struct packed {
		logic req_type;
		logic signed [31:0] sample;
		logic [16:0] pct_q16;
	} req_t;

	typedef struct packed {
		logic signed [31:0] quantile_value;
		logic [31:0] sample_total;
		logic [8:0] table_used;
		logic dropped;
	} rsp_t;

	// One table entry: value, gap and spread.
	typedef struct packed {
		logic [31:0] value;
		logic [31:0] gap;
		logic [31:0] spread;
	} tuple_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_DELTA,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_INSERT,
		ST_CMP_RD,
		ST_CMP_RUN,
		ST_CMP_LAST,
		ST_QRY_MUL,
		ST_QRY_RD,
		ST_QRY_CHK,
		ST_DONE
	} state_t;

	// Bit length of a spread, zero when the spread is not positive.
	function automatic logic [5:0] band_of(input logic [31:0] d);
		logic [5:0] b;
		b = 6'd0;
		if (!d[31]) begin
			for (int k = 0; k < 31; k++) begin
				if (d[k]) begin
					b = 6'(k + 1);
				end
			end
		end
		return b;
	endfunction

endpackage

/* rtl/streaming_quantile_sketch.sv */
// Approximate quantile summary over a stream of signed 32-bit samples. Each transaction
// is an add or a query and yields one result; the block takes one transaction at a time
// and is not ready while it works. All table work goes through one tuple RAM with one
// read and one write port, one entry per step. An add scans up to the insertion point
// and shifts the tail one place up; a compression pass may follow. The epsilon terms
// come from one shared combinational multiplier. A finished result waits in the output register,
// and the block does not return to idle while an earlier result is still waiting there.
// No clearing pass is needed after reset.
module streaming_quantile_sketch #(
	parameter int CAPACITY = sqs_pkg::CAPACITY_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  sqs_pkg::req_t   in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output sqs_pkg::rsp_t   out_data,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic [15:0]     cfg_wdata
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	sqs_pkg::state_t state_q, state_d;

	logic [15:0] eps_q;
	logic [9:0]  limit_q;
	logic [CW-1:0] used_q;
	logic [31:0] seen_q;
	sqs_pkg::req_t req_q;
	sqs_pkg::rsp_t rsp_q;
	logic rsp_valid_q;

	logic [CW-1:0] idx_q;   // read / scan index
	logic [CW-1:0] wi_q;    // compress write index
	logic [CW-1:0] pos_q;
	logic [31:0] delta_q;
	logic signed [31:0] answer_q;
	logic [63:0] cum_q;
	logic signed [63:0] target_q;
	sqs_pkg::tuple_t acc_q;   // run being folded during compression
	logic [5:0] acc_band_q;
	sqs_pkg::tuple_t last_q;
	logic [CW-1:0] last_idx_q;
	logic fold_q;             // a compression pass ran for this transaction

	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	sqs_pkg::tuple_t ram_wdata, ram_rdata;

	sqs_ram #(.WIDTH($bits(sqs_pkg::tuple_t)), .DEPTH(CAPACITY)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	// Shared multiplier: epsilon by count for the add, percentile term by count for query.
	logic [15:0] eps_c;
	logic [16:0] pct_c;
	logic signed [17:0] mul_a;
	logic [32:0] mul_b;
	logic signed [51:0] mul_p;
	assign eps_c = (eps_q < sqs_pkg::EPS_MIN) ? sqs_pkg::EPS_MIN :
		(eps_q > sqs_pkg::EPS_MAX) ? sqs_pkg::EPS_MAX : eps_q;
	assign pct_c = (req_q.pct_q16 > sqs_pkg::PCT_MAX) ? sqs_pkg::PCT_MAX : req_q.pct_q16;
	always_comb begin
		if (req_q.req_type == sqs_pkg::REQ_ADD) begin
			mul_a = {2'b00, eps_c};
			mul_b = {1'b0, seen_q} + 33'd1;
		end else begin
			mul_a = $signed({1'b0, pct_c}) - $signed({2'b00, eps_c});
			mul_b = {1'b0, seen_q};
		end
		mul_p = mul_a * $signed({1'b0, mul_b});
	end

	logic [36:0] two_eps_n;
	logic [31:0] delta_calc;
	assign two_eps_n = mul_p[51:15];
	assign delta_calc = ((two_eps_n > 37'h7FFFFFFF) ? 32'h7FFFFFFF : two_eps_n[31:0]) - 32'd1;

	// Query compare terms.
	logic [63:0] cum_next;
	logic signed [63:0] lhs;
	assign cum_next = cum_q + {32'd0, ram_rdata.gap};
	assign lhs = $signed({cum_next[46:0], 17'd0}) +
		($signed({{32{ram_rdata.spread[31]}}, ram_rdata.spread}) <<< 16);

	logic [32:0] gap_sum;
	assign gap_sum = {1'b0, acc_q.gap} + {1'b0, ram_rdata.gap};

	assign in_ready = (state_q == sqs_pkg::ST_IDLE);
	assign out_valid = rsp_valid_q;
	assign out_data = rsp_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sqs_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = sqs_pkg::ST_SCAN_RD;
				end
			end
			sqs_pkg::ST_SCAN_RD: begin
				if (req_q.req_type == sqs_pkg::REQ_QUERY) begin
					state_d = (used_q == '0) ? sqs_pkg::ST_DONE : sqs_pkg::ST_QRY_MUL;
				end else if (used_q >= CW'(CAPACITY)) begin
					state_d = sqs_pkg::ST_DONE;
				end else if (idx_q >= used_q) begin
					state_d = sqs_pkg::ST_DELTA;
				end else begin
					state_d = sqs_pkg::ST_SCAN_CHK;
				end
			end
			sqs_pkg::ST_SCAN_CHK: begin
				if ($signed(ram_rdata.value) < req_q.sample) begin
					state_d = sqs_pkg::ST_SCAN_RD;
				end else begin
					state_d = sqs_pkg::ST_DELTA;
				end
			end
			sqs_pkg::ST_DELTA: begin
				state_d = (used_q > pos_q) ? sqs_pkg::ST_SHIFT_RD : sqs_pkg::ST_INSERT;
			end
			sqs_pkg::ST_SHIFT_RD: state_d = sqs_pkg::ST_SHIFT_WR;
			sqs_pkg::ST_SHIFT_WR: begin
				state_d = (idx_q - CW'(1) > pos_q) ? sqs_pkg::ST_SHIFT_RD : sqs_pkg::ST_INSERT;
			end
			sqs_pkg::ST_INSERT: begin
				if (32'(used_q) >= 32'(limit_q) && used_q + CW'(1) > CW'(2)) begin
					state_d = sqs_pkg::ST_CMP_RD;
				end else begin
					state_d = sqs_pkg::ST_DONE;
				end
			end
			sqs_pkg::ST_CMP_RD: state_d = sqs_pkg::ST_CMP_RUN;
			sqs_pkg::ST_CMP_RUN: begin
				state_d = (idx_q + CW'(1) >= last_idx_q) ? sqs_pkg::ST_CMP_LAST :
					sqs_pkg::ST_CMP_RD;
			end
			sqs_pkg::ST_CMP_LAST: state_d = sqs_pkg::ST_DONE;
			sqs_pkg::ST_QRY_MUL: state_d = sqs_pkg::ST_QRY_RD;
			sqs_pkg::ST_QRY_RD: state_d = sqs_pkg::ST_QRY_CHK;
			sqs_pkg::ST_QRY_CHK: begin
				if (lhs > target_q || idx_q + CW'(1) >= used_q) begin
					state_d = sqs_pkg::ST_DONE;
				end else begin
					state_d = sqs_pkg::ST_QRY_RD;
				end
			end
			sqs_pkg::ST_DONE: begin
				if (!rsp_valid_q || out_ready) begin
					state_d = sqs_pkg::ST_IDLE;
				end
			end
			default: state_d = sqs_pkg::ST_IDLE;
		endcase
	end

	// RAM port control.
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = idx_q[AW-1:0];
		ram_wdata = ram_rdata;
		ram_raddr = idx_q[AW-1:0];
		unique case (state_q)
			sqs_pkg::ST_SHIFT_RD: ram_raddr = AW'(idx_q - CW'(1));
			sqs_pkg::ST_SHIFT_WR: begin
				ram_we = 1'b1;
				ram_waddr = idx_q[AW-1:0];
			end
			sqs_pkg::ST_INSERT: begin
				ram_we = 1'b1;
				ram_waddr = pos_q[AW-1:0];
				ram_wdata = '{value: req_q.sample, gap: 32'd1, spread: delta_q};
			end
			sqs_pkg::ST_CMP_RUN: begin
				// Fetch the last tuple, which is needed if the pass ends here.
				ram_raddr = last_idx_q[AW-1:0];
				// Close the open run when the next tuple starts a new band.
				if (idx_q != CW'(1) && sqs_pkg::band_of(ram_rdata.spread) != acc_band_q) begin
					ram_we = 1'b1;
					ram_waddr = wi_q[AW-1:0];
					ram_wdata = acc_q;
				end
			end
			sqs_pkg::ST_CMP_LAST: begin
				ram_we = 1'b1;
				ram_waddr = wi_q[AW-1:0];
				ram_wdata = acc_q;
			end
			sqs_pkg::ST_DONE: begin
				if (req_q.req_type == sqs_pkg::REQ_ADD && fold_q) begin
					ram_we = 1'b1;
					ram_waddr = AW'(wi_q);
					ram_wdata = last_q;
				end
			end
			default: ;
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= sqs_pkg::EPS_RESET;
			limit_q <= sqs_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sqs_pkg::CFG_EPS:   eps_q <= cfg_wdata;
				sqs_pkg::CFG_LIMIT: limit_q <= cfg_wdata[9:0];
				default: ;
			endcase
		end
	end

	// Sequencer datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sqs_pkg::ST_IDLE;
			used_q <= '0;
			seen_q <= '0;
			rsp_valid_q <= 1'b0;
			idx_q <= '0;
			wi_q <= '0;
			pos_q <= '0;
			last_idx_q <= '0;
			fold_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == sqs_pkg::ST_DONE && (!rsp_valid_q || out_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (out_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				sqs_pkg::ST_IDLE: begin
					if (in_valid) begin
						req_q <= in_data;
						idx_q <= '0;
						last_idx_q <= '0;
						fold_q <= 1'b0;
						answer_q <= '0;
						cum_q <= '0;
					end
				end
				sqs_pkg::ST_SCAN_RD: pos_q <= idx_q;
				sqs_pkg::ST_SCAN_CHK: begin
					if ($signed(ram_rdata.value) < req_q.sample) begin
						idx_q <= idx_q + CW'(1);
						pos_q <= idx_q + CW'(1);
					end
				end
				sqs_pkg::ST_DELTA: begin
					delta_q <= (pos_q == '0 || pos_q == used_q) ? 32'd0 : delta_calc;
					idx_q <= used_q;
				end
				sqs_pkg::ST_SHIFT_WR: idx_q <= idx_q - CW'(1);
				sqs_pkg::ST_INSERT: begin
					used_q <= used_q + CW'(1);
					if (seen_q != 32'hFFFFFFFF) begin
						seen_q <= seen_q + 32'd1;
					end
					idx_q <= CW'(1);
					wi_q <= CW'(1);
					last_idx_q <= used_q;
				end
				sqs_pkg::ST_CMP_RD: begin
					if (idx_q == CW'(1)) begin
						acc_band_q <= 6'd0;
					end
				end
				sqs_pkg::ST_CMP_RUN: begin
					if (idx_q == CW'(1) || sqs_pkg::band_of(ram_rdata.spread) != acc_band_q) begin
						if (idx_q != CW'(1)) begin
							wi_q <= wi_q + CW'(1);
						end
						acc_q <= ram_rdata;
						acc_band_q <= sqs_pkg::band_of(ram_rdata.spread);
					end else begin
						acc_q.gap <= gap_sum[32] ? 32'hFFFFFFFF : gap_sum[31:0];
					end
					idx_q <= idx_q + CW'(1);
				end
				sqs_pkg::ST_CMP_LAST: begin
					last_q <= ram_rdata;
					wi_q <= wi_q + CW'(1);
					used_q <= wi_q + CW'(2);
					fold_q <= 1'b1;
				end
				sqs_pkg::ST_QRY_MUL: begin
					target_q <= 64'(mul_p) <<< 1;
					answer_q <= '0;
				end
				sqs_pkg::ST_QRY_CHK: begin
					cum_q <= cum_next;
					if (idx_q == '0) begin
						answer_q <= $signed(ram_rdata.value);
					end
					if (!(lhs > target_q)) begin
						answer_q <= $signed(ram_rdata.value);
					end
					idx_q <= idx_q + CW'(1);
				end
				sqs_pkg::ST_DONE: begin
					if (!rsp_valid_q || out_ready) begin
						last_idx_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// Result register loaded as the transaction finishes.
	always_ff @(posedge clk) begin
		if (state_q == sqs_pkg::ST_DONE && (!rsp_valid_q || out_ready)) begin
			rsp_q.quantile_value <= (req_q.req_type == sqs_pkg::REQ_QUERY) ? answer_q : '0;
			rsp_q.sample_total <= seen_q;
			rsp_q.table_used <= 9'(used_q);
			rsp_q.dropped <= (req_q.req_type == sqs_pkg::REQ_ADD) && (last_idx_q == '0) &&
				(used_q >= CW'(CAPACITY));
		end
	end

endmodule

/* rtl/sqs_ram.sv */
module sqs_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Single write port, registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/sqs_checker.sv */
module sqs_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input sqs_pkg::rsp_t out_data
);

	// A result never reports more tuples than the table can hold.
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.table_used <= 9'd256) else $error("table_used too large");

	// A dropped add never returns a quantile.
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.dropped |-> out_data.quantile_value == 0)
		else $error("dropped add carries a value");

	// The block stops taking transactions right after it accepts one.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("ready after accept");

	// A pending result holds until taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

endmodule

bind streaming_quantile_sketch sqs_checker u_sqs_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
